>>> hw/rtl/scrc_pkg.sv
package scrc_pkg;

  // Reflected CRC-32 constants
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

  // Field widths
  localparam int unsigned DataW     = 8;
  localparam int unsigned CrcW      = 32;
  localparam int unsigned InTdataW  = 40;  // data_byte, expected_crc
  localparam int unsigned OutTdataW = 32;  // crc_value
  localparam int unsigned OutTuserW = 1;   // crc_match

  // Fold one byte into the running value, LSB first
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data_in);
    logic [31:0] crc;
    crc = crc_in ^ {24'h000000, data_in};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // Running value after folding the reset seed byte into all ones
  localparam logic [31:0] SeedCrcRst = crc_fold_byte(CrcOnes, 8'h00);

endpackage

>>> hw/rtl/seeded_crc32_report_check_core.sv
// Seeded CRC-32 report checker. Report bytes arrive one per transaction on the
// slave stream, the final byte marked by tlast and carrying the expected CRC in
// tdata. Each report starts from all ones with the configured seed byte folded
// in ahead of the first data byte; on the last byte the value is inverted,
// compared, and one result (crc_value in tdata, crc_match in tuser) goes out on
// the master stream. Throughput is one byte per clock, set by the combinational byte
// fold between the input register and the result register, unless a last byte waits
// on a full, stalled output. A result is registered once its last byte moves on.
// The seed write is folded into a register at write time and takes effect at
// the start of the next report. Every report must hold at least one byte.
module seeded_crc32_report_check_core
  import scrc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // seed byte write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [DataW-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [7:0] data_byte, [39:8] expected_crc
  input  logic                 s_axis_tlast,   // last_byte
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [31:0] crc_value
  output logic [OutTuserW-1:0] m_axis_tuser    // [0] crc_match
);

  logic             in_valid_q, in_valid_d;
  logic [DataW-1:0] in_data_q;
  logic             in_last_q;
  logic [CrcW-1:0]  in_exp_q;

  logic             out_valid_q, out_valid_d;
  logic [CrcW-1:0]  out_crc_q;
  logic             out_match_q;

  logic [CrcW-1:0]  crc_q, crc_d;
  logic             start_q, start_d;
  logic [CrcW-1:0]  seed_crc_q, seed_crc_d;

  logic             s_accept;
  logic             advance;
  logic [CrcW-1:0]  crc_base;
  logic [CrcW-1:0]  crc_next;
  logic [CrcW-1:0]  final_crc;

  assign cfg_ready_o = 1'b1;

  // Move the held item on unless it is a last byte facing a full, stalled output
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Byte fold
  assign crc_base  = start_q ? seed_crc_q : crc_q;
  assign crc_next  = crc_fold_byte(crc_base, in_data_q);
  assign final_crc = ~crc_next;

  // Next control state
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    crc_d   = crc_q;
    start_d = start_q;
    if (advance) begin
      if (in_last_q) begin
        crc_d   = CrcOnes;
        start_d = 1'b1;
      end else begin
        crc_d   = crc_next;
        start_d = 1'b0;
      end
    end

    seed_crc_d = seed_crc_q;
    if (cfg_valid_i) begin
      seed_crc_d = crc_fold_byte(CrcOnes, cfg_data_i);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= CrcOnes;
      start_q     <= 1'b1;
      seed_crc_q  <= SeedCrcRst;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
      start_q     <= start_d;
      seed_crc_q  <= seed_crc_d;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata[DataW-1:0];
      in_exp_q  <= s_axis_tdata[DataW +: CrcW];
      in_last_q <= s_axis_tlast;
    end
  end

  // Load the result on a last byte
  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_crc_q   <= final_crc;
      out_match_q <= (final_crc == in_exp_q);
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_crc_q;
  assign m_axis_tuser[0] = out_match_q;

endmodule

>>> hw/rtl/scrc_checker.sv
module scrc_checker
  import scrc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic [OutTuserW-1:0] m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Keep a stalled result unchanged
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Input side is never blocked while the result slot is empty
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Seed writes always complete at once
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("seed write stalled");

endmodule

bind seeded_crc32_report_check_core scrc_checker u_scrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> verif/seeded_crc32_report_check_core_tb.sv
`timescale 1ns / 100ps

module seeded_crc32_report_check_core_tb;
  import scrc_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned PhaseBytes    = 200;
  localparam int unsigned PrintCap      = 100;

  typedef struct packed {
    logic            match;
    logic [CrcW-1:0] value;
  } crc_report_t;

  typedef logic [DataW-1:0] byte_q_t [$];

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [DataW-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;   // [7:0] data_byte, [39:8] expected_crc
  logic                 s_axis_tlast;   // last_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;   // [31:0] crc_value
  logic [OutTuserW-1:0] m_axis_tuser;   // [0] crc_match

  // Predictor state: running CRC, report-start flag and seed register copy
  crc_report_t      pending_crc_q [$];
  logic [CrcW-1:0]  run_crc = CrcOnes;
  logic             at_head = 1'b1;
  logic [DataW-1:0] seed_val = '0;

  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          src_gaps_on  = 1'b0;
  bit          sink_gaps_on = 1'b0;
  bit          hold_off_req = 1'b0;

  seeded_crc32_report_check_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bit-serial reflected CRC: shift each data bit in LSB first
  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc_in,
                                               input logic [DataW-1:0] data_in);
    logic [CrcW-1:0] r;
    logic            fb;
    r = crc_in;
    for (int i = 0; i < DataW; i++) begin
      fb = r[0] ^ data_in[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  // Final inverted CRC of a whole report under a given seed
  function automatic logic [CrcW-1:0] report_crc(input logic [DataW-1:0] seed,
                                                 input byte_q_t bytes);
    logic [CrcW-1:0] c;
    c = crc_step(CrcOnes, seed);
    foreach (bytes[i]) begin
      c = crc_step(c, bytes[i]);
    end
    return ~c;
  endfunction

  function automatic byte_q_t rand_report(input int unsigned len);
    byte_q_t q;
    repeat (len) q.push_back(DataW'($urandom));
    return q;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 8);
    end else if (r < 95) begin
      return $urandom_range(9, 32);
    end
    return $urandom_range(33, 128);
  endfunction

  task automatic report_mismatch(input string what, input logic [CrcW-1:0] got,
                                 input logic [CrcW-1:0] want);
    if (mismatch_cnt < PrintCap) begin
      $display("%0t: mismatch on %s: got %08h, expected %08h", $time, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // Advance the predictor by one accepted byte; queue a result on the last one
  task automatic predict_byte(input logic [DataW-1:0] data, input logic last,
                              input logic [CrcW-1:0] want_crc);
    logic [CrcW-1:0] c;
    crc_report_t     r;
    c = at_head ? crc_step(CrcOnes, seed_val) : run_crc;
    c = crc_step(c, data);
    if (last) begin
      r.value = ~c;
      r.match = (r.value == want_crc);
      pending_crc_q.push_back(r);
      run_crc = CrcOnes;
      at_head = 1'b1;
    end else begin
      run_crc = c;
      at_head = 1'b0;
    end
  endtask

  // Offer one byte; valid stays high on return so back-to-back bytes need no gap
  task automatic push_byte(input logic [DataW-1:0] data, input logic last,
                           input logic [CrcW-1:0] want_crc);
    int unsigned gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {want_crc, data};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(data, last, want_crc);
  endtask

  // Send a full report; a bad one carries a flipped bit or a random CRC
  task automatic send_report(input byte_q_t bytes, input bit good);
    logic [CrcW-1:0] want;
    int unsigned     last_idx;
    last_idx = bytes.size() - 1;
    want = report_crc(seed_val, bytes);
    if (!good) begin
      want = ($urandom_range(0, 1) != 0) ? want ^ (32'h1 << $urandom_range(0, 31))
                                         : $urandom;
    end
    foreach (bytes[i]) begin
      push_byte(bytes[i], i == last_idx, (i == last_idx) ? want : $urandom);
    end
  endtask

  // Drop valid, wait for all results, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_crc_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [DataW-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seed_val = value;
  endtask

  // Reset seed, one-byte reports, field extremes, ignored CRC on non-last bytes
  task automatic test_reset_seed();
    send_report('{8'h00}, 1'b1);
    push_byte(8'hFF, 1'b1, 32'h0000_0000);
    push_byte(8'h00, 1'b1, 32'hFFFF_FFFF);
    push_byte(8'h5A, 1'b0, 32'hFFFF_FFFF);
    push_byte(8'hA5, 1'b0, 32'h0000_0000);
    push_byte(8'h3C, 1'b1, report_crc(seed_val, '{8'h5A, 8'hA5, 8'h3C}));
    send_report('{8'h12, 8'h34, 8'h56}, 1'b0);
  endtask

  task automatic test_seed_extremes();
    write_seed(8'hFF);
    send_report('{8'h00}, 1'b1);
    send_report('{8'hFF, 8'h00}, 1'b1);
    send_report('{8'h31}, 1'b0);
    write_seed(8'h00);
    send_report('{8'hFF}, 1'b1);
  endtask

  // A seed written inside a report applies only from the next report on
  task automatic test_seed_mid_report();
    write_seed(8'h5A);
    push_byte(8'h11, 1'b0, 32'hFFFF_FFFF);
    push_byte(8'h22, 1'b0, 32'h0000_0000);
    write_seed(8'hA5);
    push_byte(8'h33, 1'b1, report_crc(8'h5A, '{8'h11, 8'h22, 8'h33}));
    send_report('{8'h44}, 1'b1);
  endtask

  // Phases of random reports, each under its own seed and idling mix
  task automatic test_random_reports();
    int unsigned sent;
    int unsigned len;
    logic [DataW-1:0] seed;
    for (int ph = 0; ph < 8; ph++) begin
      seed = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : DataW'($urandom);
      write_seed(seed);
      src_gaps_on  = (ph % 4 == 1) || (ph % 4 == 3);
      sink_gaps_on = (ph % 4 == 2) || (ph % 4 == 3);
      sent = 0;
      while (sent < PhaseBytes) begin
        len = pick_len();
        send_report(rand_report(len), $urandom_range(0, 4) != 0);
        sent += len;
      end
    end
  endtask

  // Hold the result side off while short reports keep coming
  task automatic test_output_hold_off();
    settle();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_report(rand_report(1), $urandom_range(0, 3) != 0);
    repeat (10) send_report(rand_report($urandom_range(2, 6)), 1'b1);
  endtask

  // Result-side ready: random stalls, plus a long hold-off on request
  initial begin : drive_result_ready
    int unsigned n;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        n = sink_gaps_on ? pick_gap() : 0;
        if (n != 0) begin
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b1;
          @(posedge clk_i);
        end
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    crc_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_crc_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = pending_crc_q.pop_front();
        if (m_axis_tdata !== want.value) begin
          report_mismatch("crc_value", m_axis_tdata, want.value);
        end
        if (m_axis_tuser[0] !== want.match) begin
          report_mismatch("crc_match", CrcW'(m_axis_tuser[0]), CrcW'(want.match));
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_seed();
    test_seed_extremes();
    test_seed_mid_report();
    test_random_reports();
    test_output_hold_off();
    settle();

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/scrc_pkg.sv
hw/rtl/seeded_crc32_report_check_core.sv
hw/rtl/scrc_checker.sv
verif/seeded_crc32_report_check_core_tb.sv
